/* rtl/sobel_edge_threshold_assert.svh */
`ifndef SOBEL_EDGE_THRESHOLD_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SOBEL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SOBEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sobel_pkg.sv */
package sobel_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 8;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int DIM_W      = 12;
  localparam int THR_W      = 8;
  localparam int MAG_W      = 11;
  localparam int GRAD_W     = 10;
  localparam int SQ_W       = 22;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int EDGE_SHIFT = 6;
  localparam int WIN_N      = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET     = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = 12'd480;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd50;
  localparam logic [DIM_W-1:0] DIM_FLOOR       = 12'd3;
  localparam logic [DIM_W-1:0] WIDTH_CEIL      = DIM_W'(MAX_WIDTH);
  localparam logic [MAG_W-1:0] MIN_START       = 11'd2040;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             start_of_frame;
  } in_req_t;

  typedef struct packed {
    logic [COL_W-1:0] center_x;
    logic [ROW_W-1:0] center_y;
    logic [MAG_W-1:0] magnitude;
    logic             is_edge;
    logic [MAG_W-1:0] frame_min;
    logic [MAG_W-1:0] frame_max;
    logic             frame_done;
  } out_res_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } lm_pair_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    lm_pair_t          wr_data;
  } lm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } isqrt_stat_t;

endpackage

/* rtl/sobel_line_mem.sv */
module sobel_line_mem (
  input  logic               clk,
  input  sobel_pkg::lm_req_t req,
  output sobel_pkg::lm_pair_t rd_data
);
  import sobel_pkg::*;

  // Both line stores side by side: upper row in the high byte.
  lm_pair_t line_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      line_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= line_mem[req.rd_addr];
    end
  end

endmodule

/* rtl/sobel_isqrt.sv */
module sobel_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sobel_pkg::SQ_W-1:0]    operand,
  output logic [sobel_pkg::ROOT_W-1:0]  root,
  output sobel_pkg::isqrt_stat_t        stat
);
  import sobel_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [SQ_W-1:0]    rad;
  logic [REM_W-1:0]   rem;
  logic [ROOT_W-1:0]  root_q;
  logic [STEP_W-1:0]  cnt;
  logic               busy;
  logic               done;

  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic               fits;
  logic [REM_W-1:0]   rem_next;
  logic [ROOT_W-1:0]  root_next;

  // One root bit per cycle: bring down two radicand bits, try 4*root+1.
  always_comb begin
    rem_sh    = {rem, rad[SQ_W-1 -: 2]};
    trial     = (REM_W+2)'({root_q, 2'b01});
    fits      = rem_sh >= trial;
    rem_next  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    root_next = {root_q[ROOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(ROOT_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad    <= operand;
      rem    <= '0;
      root_q <= '0;
    end else if (busy) begin
      rad    <= {rad[SQ_W-3:0], 2'b00};
      rem    <= rem_next;
      root_q <= root_next;
    end
  end

  assign root = root_q;
  assign stat = '{busy: busy, done: done};

endmodule

/* rtl/sobel_edge_threshold.sv */
// Sobel 3x3 gradient magnitude over a raster pixel stream.
// Input channel in_valid/in_ready/in_data carries one pixel per request,
// with start_of_frame on the first pixel of a frame. Output channel
// out_valid/out_ready/out_data carries one result per interior pixel:
// window center, floor(sqrt(dx^2+dy^2)), edge flag, frame min/max so far,
// and frame_done on the last interior pixel. Border pixels give nothing.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr
// (0 image_width, 1 image_height, 2 edge_threshold); write only when idle.
// A border pixel passes through the request and the line store read and
// write-back; an interior pixel goes on through the gradient, squaring
// and sum stages and the bit-serial square root, which resolves one root
// bit per cycle and then raises its done flag, before the output stage.
// A new pixel is taken only after the previous one has gone on to the
// output register or, for a border pixel, after its write-back.
// A finished result sits in the output register; the next pixel is taken
// while it waits, and that pixel's result stalls until the register frees.
// Reset restores default sizes, zeros position and window, min 2040,
// max 0. Line stores are not cleared; rows 0 and 1 fill them each frame.
`include "sobel_edge_threshold_assert.svh"

module sobel_edge_threshold (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sobel_pkg::in_req_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sobel_pkg::out_res_t              out_data,
  input  logic                             cfg_we,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sobel_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]        state;

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [THR_W-1:0]  edge_threshold;

  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic [MAG_W-1:0]  run_min;
  logic [MAG_W-1:0]  run_max;

  logic [PIX_W-1:0]  pix_r;
  logic [ADDR_W-1:0] idx_r;
  logic [COL_W-1:0]  cx_r;
  logic [ROW_W-1:0]  cy_r;
  logic              hit_r;
  logic              last_r;
  logic [PIX_W-1:0]  win [WIN_N];

  logic [GRAD_W-1:0]   ax;
  logic [GRAD_W-1:0]   ay;
  logic [2*GRAD_W-1:0] axx;
  logic [2*GRAD_W-1:0] ayy;
  logic [2*THR_W-1:0]  thr2;
  logic [SQ_W-1:0]     sq;

  logic                accept;
  logic [DIM_W-1:0]    w_eff;
  logic [DIM_W-1:0]    h_eff;
  logic [COL_W-1:0]    x;
  logic [ROW_W-1:0]    y;
  logic [DIM_W-1:0]    xw;
  logic                hit;
  logic                last;
  logic                col_wrap;
  logic                row_wrap;
  logic [COL_W-1:0]    col_next;
  logic [ROW_W-1:0]    row_next;

  logic [GRAD_W-1:0]   rpos;
  logic [GRAD_W-1:0]   rneg;
  logic [GRAD_W-1:0]   cpos;
  logic [GRAD_W-1:0]   cneg;
  logic [SQ_W-1:0]     sq_sum;

  lm_req_t             lm_req;
  lm_pair_t            lm_rdata;
  isqrt_stat_t         sq_stat;
  logic [ROOT_W-1:0]   root;
  logic                root_start;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W-1:0]    min_next;
  logic [MAG_W-1:0]    max_next;
  logic                load;

  sobel_line_mem u_line_mem (
    .clk     (clk),
    .req     (lm_req),
    .rd_data (lm_rdata)
  );

  sobel_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (sq_sum),
    .root    (root),
    .stat    (sq_stat)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Position and window bookkeeping for the incoming pixel.
  always_comb begin
    w_eff = (image_width < DIM_FLOOR) ? DIM_FLOOR :
            (image_width > WIDTH_CEIL) ? WIDTH_CEIL : image_width;
    h_eff = (image_height < DIM_FLOOR) ? DIM_FLOOR : image_height;
    x     = in_data.start_of_frame ? '0 : col_count;
    y     = in_data.start_of_frame ? '0 : row_count;
    xw    = DIM_W'(x);
    hit   = (x >= COL_W'(2)) && (y >= ROW_W'(2)) && (xw < w_eff) && (y < h_eff);
    last  = (xw == w_eff - 1'b1) && (y == h_eff - 1'b1);
    col_wrap = ((DIM_W+1)'(xw) + 1'b1) >= (DIM_W+1)'(w_eff);
    row_wrap = ((ROW_W+1)'(y) + 1'b1) >= (ROW_W+1)'(h_eff);
    col_next = col_wrap ? '0 : x + 1'b1;
    row_next = col_wrap ? (row_wrap ? '0 : y + 1'b1) : y;
  end

  // Read both stores on request, write back the shifted column next cycle.
  always_comb begin
    lm_req.rd_en         = accept;
    lm_req.rd_addr       = x[ADDR_W-1:0];
    lm_req.wr_en         = (state == S_READ);
    lm_req.wr_addr       = idx_r;
    lm_req.wr_data.upper = lm_rdata.lower;
    lm_req.wr_data.lower = pix_r;
  end

  always_comb begin
    rpos = GRAD_W'(win[2]) + GRAD_W'({win[5], 1'b0}) + GRAD_W'(win[8]);
    rneg = GRAD_W'(win[0]) + GRAD_W'({win[3], 1'b0}) + GRAD_W'(win[6]);
    cpos = GRAD_W'(win[6]) + GRAD_W'({win[7], 1'b0}) + GRAD_W'(win[8]);
    cneg = GRAD_W'(win[0]) + GRAD_W'({win[1], 1'b0}) + GRAD_W'(win[2]);
    sq_sum     = SQ_W'(axx) + SQ_W'(ayy);
    root_start = (state == S_SUM);
  end

  always_comb begin
    mag      = MAG_W'(root);
    min_next = (mag < run_min) ? mag : run_min;
    max_next = (mag > run_max) ? mag : run_max;
    load     = (state == S_EMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
      edge_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:    image_width    <= cfg_wdata;
        REG_IMAGE_HEIGHT:   image_height   <= cfg_wdata;
        REG_EDGE_THRESHOLD: edge_threshold <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col_count <= '0;
      row_count <= '0;
      run_min   <= MIN_START;
      run_max   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            col_count <= col_next;
            row_count <= row_next;
            if (in_data.start_of_frame) begin
              run_min <= MIN_START;
              run_max <= '0;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= hit_r ? S_GRAD : S_IDLE;
        end
        S_GRAD: state <= S_SQ;
        S_SQ:   state <= S_SUM;
        S_SUM:  state <= S_ROOT;
        S_ROOT: begin
          if (sq_stat.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold the result until the output register frees.
          if (load) begin
            run_min <= min_next;
            run_max <= max_next;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r  <= in_data.pixel;
      idx_r  <= x[ADDR_W-1:0];
      cx_r   <= x - 1'b1;
      cy_r   <= y - 1'b1;
      hit_r  <= hit;
      last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_N; i++) begin
        win[i] <= '0;
      end
    end else if (state == S_READ) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= lm_rdata.upper;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= lm_rdata.lower;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GRAD) begin
      ax <= (rpos >= rneg) ? rpos - rneg : rneg - rpos;
      ay <= (cpos >= cneg) ? cpos - cneg : cneg - cpos;
    end
    if (state == S_SQ) begin
      axx  <= ax * ax;
      ayy  <= ay * ay;
      thr2 <= edge_threshold * edge_threshold;
    end
    if (state == S_SUM) begin
      sq <= sq_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.center_x   <= cx_r;
      out_data.center_y   <= cy_r;
      out_data.magnitude  <= mag;
      out_data.is_edge    <= sq >= (SQ_W'(thr2) << EDGE_SHIFT);
      out_data.frame_min  <= min_next;
      out_data.frame_max  <= max_next;
      out_data.frame_done <= last_r;
    end
  end

  `SOBEL_ASSERT_NOW(a_minmax_bracket, out_valid, out_data.frame_min <= out_data.magnitude && out_data.magnitude <= out_data.frame_max, "frame min or max does not bracket magnitude")
  `SOBEL_ASSERT_NOW(a_mem_no_overlap, lm_req.wr_en, !lm_req.rd_en, "line store read overlaps write-back")
  `SOBEL_ASSERT_NOW(a_root_idle, in_ready, !sq_stat.busy, "request taken while root unit busy")
  `SOBEL_ASSERT_NEXT(a_read_follows, in_valid && in_ready, state == S_READ, "line store read not followed")
  `SOBEL_ASSERT_NEXT(a_emit_holds, state == S_EMIT && out_valid && !out_ready, state == S_EMIT && out_valid, "pending result dropped")

endmodule
